/* hdl/cfr_pkg.sv */
// Shared types, constants and the CRC-8 step for the frame receiver.
package cfr_pkg;

    localparam int FRAME_BYTES_DEF = 32;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    localparam logic [7:0] TAIL_FIRST  = 8'h55;
    localparam logic [7:0] TAIL_SECOND = 8'hAA;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_LEN,
        ST_TYPE,
        ST_CMD,
        ST_DATA,
        ST_CRC,
        ST_TAIL1,
        ST_TAIL2,
        ST_DRAIN_RD,
        ST_DRAIN_WR
    } state_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_CRC  = 2'd1,
        STAT_TAIL = 2'd2,
        STAT_LEN  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OUT_LEN_ERR,
        OUT_SINGLE,
        OUT_PAYLOAD
    } out_kind_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      load_len;
        logic      load_type;
        logic      load_cmd;
        logic      load_crc;
        logic      load_tail1;
        logic      crc_clear;
        logic      crc_update;
        logic      store_byte;
        logic      rd_issue;
        logic      cnt_clear;
        logic      cnt_inc;
        logic      out_load;
        out_kind_t out_kind;
        status_t   out_status;
        logic      out_last;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic hdr_first;
        logic hdr_second;
        logic len_too_long;
        logic len_zero;
        logic count_done;
        logic tail_ok;
        logic crc_ok;
        logic out_free;
    } stat_t;

    // CRC-8, MSB first, one byte per call
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hdl/cfr_ctrl.sv */
// Frame receiver controller: header hunt, field sequencing and payload drain.
module cfr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cfr_pkg::stat_t stat,
    output cfr_pkg::cmd_t  cmd
);
    import cfr_pkg::*;

    state_t state_reg, state_next;
    logic   saw_reg, saw_next;
    logic   byte_state;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
            saw_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            saw_reg   <= saw_next;
        end
    end

    assign byte_state = (state_reg != ST_DRAIN_RD) && (state_reg != ST_DRAIN_WR);
    assign s_ready    = byte_state && stat.out_free;
    assign accept     = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        saw_next       = saw_reg;
        cmd            = '0;
        cmd.out_kind   = OUT_SINGLE;
        cmd.out_status = STAT_OK;
        unique case (state_reg)
            ST_HUNT: begin
                if (accept) begin
                    if (saw_reg && stat.hdr_second) begin
                        saw_next   = 1'b0;
                        state_next = ST_LEN;
                    end else begin
                        saw_next = stat.hdr_first;
                    end
                end
            end
            ST_LEN: begin
                if (accept) begin
                    if (stat.len_too_long) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_kind   = OUT_LEN_ERR;
                        cmd.out_status = STAT_LEN;
                        cmd.out_last   = 1'b1;
                        state_next     = ST_HUNT;
                    end else begin
                        cmd.load_len  = 1'b1;
                        cmd.crc_clear = 1'b1;
                        cmd.cnt_clear = 1'b1;
                        state_next    = ST_TYPE;
                    end
                end
            end
            ST_TYPE: begin
                if (accept) begin
                    cmd.load_type  = 1'b1;
                    cmd.crc_update = 1'b1;
                    state_next     = ST_CMD;
                end
            end
            ST_CMD: begin
                if (accept) begin
                    cmd.load_cmd   = 1'b1;
                    cmd.crc_update = 1'b1;
                    cmd.cnt_clear  = 1'b1;
                    state_next     = stat.len_zero ? ST_CRC : ST_DATA;
                end
            end
            ST_DATA: begin
                if (accept) begin
                    cmd.store_byte = 1'b1;
                    cmd.crc_update = 1'b1;
                    cmd.cnt_inc    = 1'b1;
                    if (stat.count_done) begin
                        state_next = ST_CRC;
                    end
                end
            end
            ST_CRC: begin
                if (accept) begin
                    cmd.load_crc = 1'b1;
                    state_next   = ST_TAIL1;
                end
            end
            ST_TAIL1: begin
                if (accept) begin
                    cmd.load_tail1 = 1'b1;
                    state_next     = ST_TAIL2;
                end
            end
            ST_TAIL2: begin
                if (accept) begin
                    saw_next = 1'b0;
                    // tail is judged before the CRC
                    if (!stat.tail_ok) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = STAT_TAIL;
                        cmd.out_last   = 1'b1;
                        state_next     = ST_HUNT;
                    end else if (!stat.crc_ok) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = STAT_CRC;
                        cmd.out_last   = 1'b1;
                        state_next     = ST_HUNT;
                    end else if (stat.len_zero) begin
                        cmd.out_load = 1'b1;
                        cmd.out_last = 1'b1;
                        state_next   = ST_HUNT;
                    end else begin
                        cmd.cnt_clear = 1'b1;
                        state_next    = ST_DRAIN_RD;
                    end
                end
            end
            ST_DRAIN_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_DRAIN_WR;
            end
            ST_DRAIN_WR: begin
                // hold the read data until the output stage frees
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_PAYLOAD;
                    cmd.out_last = stat.count_done;
                    cmd.cnt_inc  = 1'b1;
                    state_next   = stat.count_done ? ST_HUNT : ST_DRAIN_RD;
                end
            end
            default: begin
                state_next = ST_HUNT;
            end
        endcase
    end

`ifndef SYNTH
    a_rd_then_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |=> state_reg == ST_DRAIN_WR)
        else $error("store read not followed by output step");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a held result");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.store_byte && cmd.rd_issue))
        else $error("store written and read together");

    a_tail_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAIL2 && accept) |=>
            (state_reg == ST_HUNT || state_reg == ST_DRAIN_RD) && !saw_reg)
        else $error("bad exit from tail");
`endif

endmodule

/* hdl/cfr_datapath.sv */
// Frame receiver datapath: field registers, CRC, payload store and result register.
module cfr_datapath #(
    parameter int FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [7:0]     s_rx_byte,
    input  cfr_pkg::cmd_t  cmd,
    output cfr_pkg::stat_t stat,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_status,
    output logic [7:0]     m_frame_type,
    output logic [7:0]     m_frame_command,
    output logic [7:0]     m_payload_length,
    output logic [7:0]     m_payload_byte,
    output logic           m_payload_valid,
    output logic           m_last
);
    import cfr_pkg::*;

    localparam int PAYLOAD_MAX = FRAME_BYTES - 8;
    localparam int STORE_DEPTH = (PAYLOAD_MAX < 2) ? 2 : PAYLOAD_MAX;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = (PAYLOAD_MAX < 1) ? 1 : $clog2(PAYLOAD_MAX + 1);
    localparam logic [7:0] LEN_LIMIT = 8'(PAYLOAD_MAX);

    logic [7:0]       len_reg;
    logic [7:0]       type_reg;
    logic [7:0]       cmd_reg;
    logic [7:0]       crc_reg;
    logic [7:0]       rx_crc_reg;
    logic [7:0]       tail1_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [8:0]       cnt_plus;
    logic [7:0]       store_mem [STORE_DEPTH];
    logic [7:0]       rd_data_reg;

    logic       out_valid_reg;
    status_t    status_reg;
    logic [7:0] otype_reg;
    logic [7:0] ocmd_reg;
    logic [7:0] olen_reg;
    logic [7:0] obyte_reg;
    logic       opv_reg;
    logic       olast_reg;

    // field registers and running CRC
    always_ff @(posedge aclk) begin
        if (cmd.load_len) begin
            len_reg <= s_rx_byte;
        end
        if (cmd.load_type) begin
            type_reg <= s_rx_byte;
        end
        if (cmd.load_cmd) begin
            cmd_reg <= s_rx_byte;
        end
        if (cmd.load_crc) begin
            rx_crc_reg <= s_rx_byte;
        end
        if (cmd.load_tail1) begin
            tail1_reg <= s_rx_byte;
        end
        if (cmd.crc_clear) begin
            crc_reg <= 8'h00;
        end else if (cmd.crc_update) begin
            crc_reg <= crc8_step(crc_reg, s_rx_byte);
        end
    end

    // byte counter: write address while filling, read address while draining
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_clear) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign cnt_plus = 9'(cnt_reg) + 9'd1;

    // payload store, registered read
    always_ff @(posedge aclk) begin
        if (cmd.store_byte) begin
            store_mem[cnt_reg[ADDR_W-1:0]] <= s_rx_byte;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= store_mem[cnt_reg[ADDR_W-1:0]];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            status_reg <= cmd.out_status;
            olast_reg  <= cmd.out_last;
            case (cmd.out_kind)
                OUT_LEN_ERR: begin
                    otype_reg <= 8'h00;
                    ocmd_reg  <= 8'h00;
                    olen_reg  <= s_rx_byte;
                    obyte_reg <= 8'h00;
                    opv_reg   <= 1'b0;
                end
                OUT_PAYLOAD: begin
                    otype_reg <= type_reg;
                    ocmd_reg  <= cmd_reg;
                    olen_reg  <= len_reg;
                    obyte_reg <= rd_data_reg;
                    opv_reg   <= 1'b1;
                end
                default: begin
                    otype_reg <= type_reg;
                    ocmd_reg  <= cmd_reg;
                    olen_reg  <= len_reg;
                    obyte_reg <= 8'h00;
                    opv_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign stat.hdr_first    = (s_rx_byte == HDR_FIRST);
    assign stat.hdr_second   = (s_rx_byte == HDR_SECOND);
    assign stat.len_too_long = (s_rx_byte > LEN_LIMIT);
    assign stat.len_zero     = (len_reg == 8'h00);
    assign stat.count_done   = (cnt_plus >= {1'b0, len_reg});
    assign stat.tail_ok      = (tail1_reg == TAIL_FIRST) && (s_rx_byte == TAIL_SECOND);
    assign stat.crc_ok       = (crc_reg == rx_crc_reg);
    assign stat.out_free     = !out_valid_reg || m_ready;

    assign m_valid          = out_valid_reg;
    assign m_status         = status_reg;
    assign m_frame_type     = otype_reg;
    assign m_frame_command  = ocmd_reg;
    assign m_payload_length = olen_reg;
    assign m_payload_byte   = obyte_reg;
    assign m_payload_valid  = opv_reg;
    assign m_last           = olast_reg;

endmodule

/* hdl/crc8_frame_receiver.sv */
// Top level of the CRC-8 frame receiver: controller plus datapath.
// Bytes are taken one per cycle while no result is held back by the sink; a frame
// AA 55, length, type, command, payload, CRC, 55 AA is checked (CRC-8 poly 0x07, init 0,
// over type, command and payload, tail judged before CRC). A rejected frame, an empty
// good frame or a length above FRAME_BYTES-8 gives one result carrying last. A good frame
// of N payload bytes gives N results, the last one marked; they are read back from the
// payload store through its registered read port, each result passing a read state and
// then an output state, and no byte is accepted during this drain. The store needs
// no clearing pass after reset.
module crc8_frame_receiver #(
    parameter int FRAME_BYTES = cfr_pkg::FRAME_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [7:0] m_frame_type,
    output logic [7:0] m_frame_command,
    output logic [7:0] m_payload_length,
    output logic [7:0] m_payload_byte,
    output logic       m_payload_valid,
    output logic       m_last
);
    import cfr_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    cfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cfr_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_rx_byte        (s_rx_byte),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_frame_type     (m_frame_type),
        .m_frame_command  (m_frame_command),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_payload_valid  (m_payload_valid),
        .m_last           (m_last)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the CRC-8 frame receiver: frame traffic in, payload runs out.
`timescale 1ns / 1ps

module tb;
    import cfr_pkg::*;

    localparam int PAYLOAD_MAX = FRAME_BYTES_DEF - 8;
    localparam int QUIET_LIMIT = 1000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        status_t    status;
        logic [7:0] ftype;
        logic [7:0] fcmd;
        logic [7:0] flen;
        logic [7:0] pbyte;
        logic       pvalid;
        logic       plast;
    } frame_result_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_rx_byte;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_status;
    logic [7:0] m_frame_type;
    logic [7:0] m_frame_command;
    logic [7:0] m_payload_length;
    logic [7:0] m_payload_byte;
    logic       m_payload_valid;
    logic       m_last;

    // Shadow of the deframer state
    state_t     rx_phase;
    logic       hdr_armed;
    logic [7:0] want_len;
    logic [4:0] data_cnt;
    logic [7:0] crc_acc;
    logic [7:0] hold_type;
    logic [7:0] hold_cmd;
    logic [7:0] hold_crc;
    logic [7:0] hold_tail;
    logic [7:0] payload_mem [PAYLOAD_MAX];

    frame_result_t pending_results[$];
    logic [7:0]    frame_body[$];

    int  fail_count;
    int  bytes_sent;
    int  results_taken;
    int  results_seen;
    int  sink_wait;
    int  quiet_cycles;
    bit  src_idle;
    bit  sink_idle;

    crc8_frame_receiver i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_frame_type     (m_frame_type),
        .m_frame_command  (m_frame_command),
        .m_payload_length (m_payload_length),
        .m_payload_byte   (m_payload_byte),
        .m_payload_valid  (m_payload_valid),
        .m_last           (m_last)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] r;
        r = acc ^ d;
        repeat (8) r = (r << 1) ^ (r[7] ? CRC_POLY : 8'h00);
        return r;
    endfunction

    function automatic void flag_error(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $realtime, what);
        end
    endfunction

    function automatic void push_result(input status_t st, input logic [7:0] ft,
                                        input logic [7:0] fc, input logic [7:0] fl,
                                        input logic [7:0] pb, input logic pv,
                                        input logic pl);
        frame_result_t r;
        r.status = st;
        r.ftype  = ft;
        r.fcmd   = fc;
        r.flen   = fl;
        r.pbyte  = pb;
        r.pvalid = pv;
        r.plast  = pl;
        pending_results.push_back(r);
    endfunction

    // Advance the shadow deframer by one accepted byte
    function automatic void predict_byte(input logic [7:0] b);
        int n;
        case (rx_phase)
            ST_HUNT: begin
                if (hdr_armed && b == HDR_SECOND) begin
                    hdr_armed = 1'b0;
                    rx_phase  = ST_LEN;
                end else begin
                    hdr_armed = (b == HDR_FIRST);
                end
            end
            ST_LEN: begin
                if (b > PAYLOAD_MAX) begin
                    push_result(STAT_LEN, 8'h00, 8'h00, b, 8'h00, 1'b0, 1'b1);
                    rx_phase = ST_HUNT;
                end else begin
                    want_len = b;
                    crc_acc  = 8'h00;
                    data_cnt = '0;
                    rx_phase = ST_TYPE;
                end
            end
            ST_TYPE: begin
                hold_type = b;
                crc_acc   = crc8_fold(crc_acc, b);
                rx_phase  = ST_CMD;
            end
            ST_CMD: begin
                hold_cmd = b;
                crc_acc  = crc8_fold(crc_acc, b);
                data_cnt = '0;
                rx_phase = (want_len == 8'h00) ? ST_CRC : ST_DATA;
            end
            ST_DATA: begin
                if (data_cnt < PAYLOAD_MAX) begin
                    payload_mem[data_cnt] = b;
                end
                crc_acc  = crc8_fold(crc_acc, b);
                data_cnt = data_cnt + 5'd1;
                if (data_cnt >= want_len) begin
                    rx_phase = ST_CRC;
                end
            end
            ST_CRC: begin
                hold_crc = b;
                rx_phase = ST_TAIL1;
            end
            ST_TAIL1: begin
                hold_tail = b;
                rx_phase  = ST_TAIL2;
            end
            default: begin
                if (hold_tail != TAIL_FIRST || b != TAIL_SECOND) begin
                    push_result(STAT_TAIL, hold_type, hold_cmd, want_len, 8'h00, 1'b0, 1'b1);
                end else if (crc_acc != hold_crc) begin
                    push_result(STAT_CRC, hold_type, hold_cmd, want_len, 8'h00, 1'b0, 1'b1);
                end else if (want_len == 8'h00) begin
                    push_result(STAT_OK, hold_type, hold_cmd, 8'h00, 8'h00, 1'b0, 1'b1);
                end else begin
                    n = (want_len > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(want_len);
                    for (int i = 0; i < n; i++) begin
                        push_result(STAT_OK, hold_type, hold_cmd, want_len, payload_mem[i],
                                    1'b1, (i == n - 1));
                    end
                end
                hdr_armed = 1'b0;
                rx_phase  = ST_HUNT;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_idle ? $urandom_range(0, 15) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_rx_byte = b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic wait_all_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Send AA 55, length and, unless the length is refused, the rest of the frame
    task automatic send_frame(input logic [7:0] len, input logic [7:0] ftype,
                              input logic [7:0] fcmd, input logic [7:0] crc_flip,
                              input logic [7:0] t1, input logic [7:0] t2);
        logic [7:0] crc;
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(len);
        if (len > PAYLOAD_MAX) begin
            return;
        end
        crc = crc8_fold(8'h00, ftype);
        send_byte(ftype);
        crc = crc8_fold(crc, fcmd);
        send_byte(fcmd);
        foreach (frame_body[i]) begin
            crc = crc8_fold(crc, frame_body[i]);
            send_byte(frame_body[i]);
        end
        send_byte(crc ^ crc_flip);
        send_byte(t1);
        send_byte(t2);
    endtask

    task automatic fill_body(input int len);
        frame_body.delete();
        repeat (len) frame_body.push_back(8'($urandom));
    endtask

    task automatic test_good_frames();
        frame_body.delete();
        send_frame(8'd0, 8'h00, 8'hFF, 8'h00, TAIL_FIRST, TAIL_SECOND);
        frame_body.push_back(8'hFF);
        send_frame(8'd1, 8'hFF, 8'h00, 8'h00, TAIL_FIRST, TAIL_SECOND);
        frame_body.delete();
        for (int i = 0; i < PAYLOAD_MAX; i++) begin
            frame_body.push_back((i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hFF : 8'($urandom));
        end
        send_frame(8'(PAYLOAD_MAX), 8'hA5, 8'h5A, 8'h00, TAIL_FIRST, TAIL_SECOND);
        wait_all_results();
    endtask

    task automatic test_length_limit();
        send_frame(8'(PAYLOAD_MAX + 1), 8'h00, 8'h00, 8'h00, TAIL_FIRST, TAIL_SECOND);
        send_frame(8'hFF, 8'h00, 8'h00, 8'h00, TAIL_FIRST, TAIL_SECOND);
    endtask

    task automatic test_bad_frames();
        fill_body(3);
        send_frame(8'd3, 8'h12, 8'h34, 8'h01, TAIL_FIRST, TAIL_SECOND);
        send_frame(8'd3, 8'h12, 8'h34, 8'h00, TAIL_SECOND, TAIL_SECOND);
        send_frame(8'd3, 8'h12, 8'h34, 8'h00, TAIL_FIRST, TAIL_FIRST);
        // tail fault must win over a CRC fault
        send_frame(8'd3, 8'h12, 8'h34, 8'h80, 8'h00, 8'h00);
    endtask

    task automatic test_header_hunt();
        send_byte(HDR_SECOND);
        send_byte(HDR_FIRST);
        send_byte(8'h12);
        send_byte(HDR_SECOND);
        // a repeated first header byte keeps the hunt armed
        send_byte(HDR_FIRST);
        frame_body.delete();
        send_frame(8'd0, 8'h77, 8'h88, 8'h00, TAIL_FIRST, TAIL_SECOND);
    endtask

    task automatic random_frame();
        int         kind;
        int         len;
        int         noise;
        logic [7:0] flip;
        logic [7:0] t1;
        logic [7:0] t2;
        src_idle  = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
        noise = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 4) : 0;
        repeat (noise) send_byte(($urandom_range(0, 9) == 0) ? HDR_FIRST : 8'($urandom));
        kind = $urandom_range(0, 99);
        len  = ($urandom_range(0, 4) == 0) ? $urandom_range(9, PAYLOAD_MAX)
                                           : $urandom_range(0, 8);
        flip = 8'h00;
        t1   = TAIL_FIRST;
        t2   = TAIL_SECOND;
        if (kind < 6) begin
            len = $urandom_range(PAYLOAD_MAX + 1, 255);
        end else if (kind < 12) begin
            flip = 8'($urandom_range(1, 255));
        end else if (kind < 17) begin
            t1 = 8'($urandom);
            if (t1 == TAIL_FIRST) t1 = ~t1;
        end else if (kind < 22) begin
            t2 = 8'($urandom);
            if (t2 == TAIL_SECOND) t2 = ~t2;
        end else if (kind < 28) begin
            // abandon the frame part way and let the receiver resync
            send_byte(HDR_FIRST);
            send_byte(HDR_SECOND);
            send_byte(8'(len));
            repeat ($urandom_range(0, len + 2)) send_byte(8'($urandom));
            return;
        end
        fill_body((len > PAYLOAD_MAX) ? 0 : len);
        send_frame(8'(len), 8'($urandom), 8'($urandom), flip, t1, t2);
    endtask

    task automatic test_random_traffic();
        int frames;
        frames = 0;
        while (bytes_sent < 470) begin
            random_frame();
            frames++;
            if (frames % 12 == 0) begin
                wait_all_results();
            end
        end
    endtask

    // Sink: while sink_idle is set, hold m_ready low for a random wait after every transfer
    always @(negedge aclk) begin
        if (results_taken != results_seen) begin
            results_seen = results_taken;
            sink_wait    = sink_idle ? $urandom_range(0, 15) : 0;
        end
        if (sink_wait > 0) begin
            m_ready = 1'b0;
            sink_wait--;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_taken++;
            if (pending_results.size() == 0) begin
                flag_error($sformatf("unexpected result: status %0d len %0d byte %02h last %b",
                                     m_status, m_payload_length, m_payload_byte, m_last));
            end else begin
                want = pending_results.pop_front();
                if (m_status != want.status || m_frame_type != want.ftype ||
                    m_frame_command != want.fcmd || m_payload_length != want.flen ||
                    m_payload_byte != want.pbyte || m_payload_valid != want.pvalid ||
                    m_last != want.plast) begin
                    flag_error($sformatf({"mismatch: expected st %0d ty %02h cmd %02h len %0d ",
                                          "pb %02h pv %b last %b, got st %0d ty %02h cmd %02h ",
                                          "len %0d pb %02h pv %b last %b"},
                                         want.status, want.ftype, want.fcmd, want.flen,
                                         want.pbyte, want.pvalid, want.plast,
                                         m_status, m_frame_type, m_frame_command,
                                         m_payload_length, m_payload_byte,
                                         m_payload_valid, m_last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_rx_byte     = 8'h00;
        m_ready       = 1'b0;
        fail_count    = 0;
        bytes_sent    = 0;
        results_taken = 0;
        results_seen  = 0;
        sink_wait     = 0;
        quiet_cycles  = 0;
        src_idle      = 1'b0;
        sink_idle     = 1'b0;
        rx_phase      = ST_HUNT;
        hdr_armed     = 1'b0;
        want_len      = 8'h00;
        data_cnt      = '0;
        crc_acc       = 8'h00;
        hold_type     = 8'h00;
        hold_cmd      = 8'h00;
        hold_crc      = 8'h00;
        hold_tail     = 8'h00;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_good_frames();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        test_length_limit();
        test_bad_frames();
        test_header_hunt();
        test_random_traffic();

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* crc8_frame_receiver.f */
hdl/cfr_pkg.sv
hdl/cfr_ctrl.sv
hdl/cfr_datapath.sv
hdl/crc8_frame_receiver.sv
tb/tb.sv
